@@ rtl/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants
// Sizes, frame word and broadcast control for the lfu page replacement block.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS  = 16;
    localparam int COUNT_BITS = 16;

    localparam int SLOT_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NFR_W   = $clog2(MAX_FRAMES + 1);
    localparam int STAMP_W = 32;
    localparam int CFG_W   = 5;
    localparam int IN_PAGE_W  = 16;
    localparam int OUT_SLOT_W = 4;

    typedef logic [PAGE_BITS-1:0]  page_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [NFR_W-1:0]      nfr_t;
    typedef logic [STAMP_W-1:0]    stamp_t;

    localparam count_t COUNT_MAX = '1;
    localparam stamp_t STAMP_MAX = '1;

    // search word moving down the row of frames
    typedef struct packed {
        logic   vld;
        page_t  page;
        logic   done;
        logic   hit;
        slot_t  slot;
        count_t best_cnt;
        stamp_t best_stamp;
        slot_t  best_slot;
        page_t  best_tag;
    } word_t;

    // values broadcast to every frame
    typedef struct packed {
        nfr_t   n;
        stamp_t stamp;
        logic   ld_en;
        slot_t  ld_slot;
        page_t  ld_page;
    } bcast_t;

    function automatic stamp_t sat_inc32(input stamp_t v);
        return (v == STAMP_MAX) ? v : v + stamp_t'(1);
    endfunction

    function automatic page_t page_from_in(input logic [IN_PAGE_W-1:0] p);
        logic [63:0] x;
        x = 64'(p);
        return x[PAGE_BITS-1:0];
    endfunction

    function automatic logic [IN_PAGE_W-1:0] page_to_out(input page_t p);
        logic [63:0] x;
        x = 64'(p);
        return x[IN_PAGE_W-1:0];
    endfunction

    function automatic logic [OUT_SLOT_W-1:0] slot_to_out(input slot_t s);
        logic [63:0] x;
        x = 64'(s);
        return x[OUT_SLOT_W-1:0];
    endfunction

endpackage

@@ rtl/lfu_ifs.sv @@
// ----------------------------------------------------------------------------
// lfu channel interfaces
// Valid/ready channels for page references, results and configuration.
// ----------------------------------------------------------------------------
interface lfu_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface lfu_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [3:0]  frame_slot;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [31:0] fault_total;

    modport source (output valid, output hit, output frame_slot, output evicted_valid,
                    output evicted_page, output fault_total, input ready);
    modport sink   (input valid, input hit, input frame_slot, input evicted_valid,
                    input evicted_page, input fault_total, output ready);
endinterface

interface lfu_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] frames_in_use;

    modport source (output valid, output frames_in_use, input ready);
    modport sink   (input valid, input frames_in_use, output ready);
endinterface

@@ rtl/lfu_cell.sv @@
// ----------------------------------------------------------------------------
// lfu_cell: one page frame
// Holds tag, use count and load stamp; checks the passing search word.
// ----------------------------------------------------------------------------
module lfu_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  lfu_pkg::slot_t  idx,
    input  lfu_pkg::bcast_t bc,
    input  lfu_pkg::word_t  word_in,
    output lfu_pkg::word_t  word_out
);

    logic             valid_reg;
    lfu_pkg::page_t   tag_reg;
    lfu_pkg::count_t  cnt_reg;
    lfu_pkg::stamp_t  stamp_reg;
    lfu_pkg::word_t   word_reg;
    lfu_pkg::word_t   word_next;

    logic            active;
    logic            scan_load;
    logic            ev_load;
    logic            bump;
    logic            better;
    lfu_pkg::page_t  ld_page;

    assign active = lfu_pkg::NFR_W'(idx) < bc.n;
    assign ev_load = bc.ld_en && (bc.ld_slot == idx);
    assign better = (cnt_reg < word_in.best_cnt) ||
                    ((cnt_reg == word_in.best_cnt) && (stamp_reg < word_in.best_stamp));

    always_comb
    begin
        word_next = word_in;
        scan_load = 1'b0;
        bump      = 1'b0;
        if (word_in.vld && active && !word_in.done)
        begin
            if (!valid_reg)
            begin
                scan_load      = 1'b1;
                word_next.done = 1'b1;
                word_next.hit  = 1'b0;
                word_next.slot = idx;
            end
            else if (tag_reg == word_in.page)
            begin
                bump           = 1'b1;
                word_next.done = 1'b1;
                word_next.hit  = 1'b1;
                word_next.slot = idx;
            end
            else if ((idx == '0) || better)
            begin
                word_next.best_cnt   = cnt_reg;
                word_next.best_stamp = stamp_reg;
                word_next.best_slot  = idx;
                word_next.best_tag   = tag_reg;
            end
        end
    end

    assign ld_page = scan_load ? word_in.page : bc.ld_page;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tag_reg   <= '0;
            cnt_reg   <= '0;
            stamp_reg <= '0;
            word_reg  <= '0;
        end
        else
        begin
            word_reg <= word_next;
            if (scan_load || ev_load)
            begin
                valid_reg <= 1'b1;
                tag_reg   <= ld_page;
                cnt_reg   <= lfu_pkg::count_t'(1);
                stamp_reg <= bc.stamp;
            end
            else if (bump && (cnt_reg != lfu_pkg::COUNT_MAX))
            begin
                cnt_reg <= cnt_reg + lfu_pkg::count_t'(1);
            end
        end
    end

    assign word_out = word_reg;

endmodule

@@ rtl/lfu_chain.sv @@
// ----------------------------------------------------------------------------
// lfu_chain: row of frame cells
// The search word moves one frame per cycle from slot 0 upward.
// ----------------------------------------------------------------------------
module lfu_chain (
    input  logic            clk,
    input  logic            rst_n,
    input  lfu_pkg::bcast_t bc,
    input  lfu_pkg::word_t  word_in,
    output lfu_pkg::word_t  word_out
);

    lfu_pkg::word_t link [lfu_pkg::MAX_FRAMES+1];

    assign link[0] = word_in;

    for (genvar i = 0; i < lfu_pkg::MAX_FRAMES; i++)
    begin : g_cell
        lfu_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (lfu_pkg::SLOT_W'(i)),
            .bc       (bc),
            .word_in  (link[i]),
            .word_out (link[i+1])
        );
    end

    assign word_out = link[lfu_pkg::MAX_FRAMES];

endmodule

@@ rtl/lfu_page_replacement.sv @@
// ----------------------------------------------------------------------------
// lfu_page_replacement: least frequently used page replacement
// One page reference in, one hit/fault word out.
//
// req carries a page number word, rsp returns hit, frame slot, evicted page
// and the running fault count, cfg writes frames_in_use (always ready).
// A reference walks a row of MAX_FRAMES frame cells, one cell per cycle,
// then a tail stage settles the victim and the counters. The row holds one
// reference at a time, so the next reference is taken the cycle after the
// previous result is committed. The output register lets a new reference
// enter while the last result waits; if rsp stays stalled the finished word
// waits in the tail stage and req stays low until it moves on.
// Reset empties all frames, clears the reference and fault counters and sets
// frames_in_use to 16.
// ----------------------------------------------------------------------------
module lfu_page_replacement (
    input  logic        clk,
    input  logic        rst_n,
    lfu_req_if.sink     req,
    lfu_rsp_if.source   rsp,
    lfu_cfg_if.sink     cfg
);

    logic [lfu_pkg::CFG_W-1:0] fiu_reg;
    lfu_pkg::nfr_t             n_act;
    lfu_pkg::stamp_t           ref_reg;
    lfu_pkg::stamp_t           fault_reg;
    lfu_pkg::stamp_t           fault_next;
    logic                      busy_reg;
    logic                      pend_reg;
    lfu_pkg::word_t            tail_reg;
    lfu_pkg::word_t            word_in;
    lfu_pkg::word_t            word_out;
    lfu_pkg::bcast_t           bc;
    logic                      accept;
    logic                      commit;
    logic                      is_hit;

    logic        rsp_valid_reg;
    logic        hit_reg;
    logic [3:0]  slot_reg;
    logic        ev_valid_reg;
    logic [15:0] ev_page_reg;
    logic [31:0] total_reg;

    // active frame count, clamped to one and to the row length
    always_comb
    begin
        if (fiu_reg == '0)
            n_act = lfu_pkg::nfr_t'(1);
        else if (int'(fiu_reg) > lfu_pkg::MAX_FRAMES)
            n_act = lfu_pkg::nfr_t'(lfu_pkg::MAX_FRAMES);
        else
            n_act = lfu_pkg::nfr_t'(fiu_reg);
    end

    assign req.ready = !busy_reg;
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && !busy_reg;
    assign commit    = pend_reg && (!rsp_valid_reg || rsp.ready);
    assign is_hit    = tail_reg.done && tail_reg.hit;

    always_comb
    begin
        word_in      = '0;
        word_in.vld  = accept;
        word_in.page = lfu_pkg::page_from_in(req.page_number);
    end

    always_comb
    begin
        bc.n       = n_act;
        bc.stamp   = ref_reg;
        bc.ld_en   = commit && !tail_reg.done;
        bc.ld_slot = tail_reg.best_slot;
        bc.ld_page = tail_reg.page;
    end

    assign fault_next = is_hit ? fault_reg : lfu_pkg::sat_inc32(fault_reg);

    lfu_chain u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .bc       (bc),
        .word_in  (word_in),
        .word_out (word_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg       <= lfu_pkg::CFG_W'(16);
            ref_reg       <= '0;
            fault_reg     <= '0;
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                fiu_reg <= cfg.frames_in_use;
            if (accept)
                busy_reg <= 1'b1;
            else if (commit)
                busy_reg <= 1'b0;
            if (word_out.vld)
                pend_reg <= 1'b1;
            else if (commit)
                pend_reg <= 1'b0;
            if (commit)
            begin
                ref_reg       <= lfu_pkg::sat_inc32(ref_reg);
                fault_reg     <= fault_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (word_out.vld)
            tail_reg <= word_out;
        if (commit)
        begin
            hit_reg      <= is_hit;
            slot_reg     <= tail_reg.done ? lfu_pkg::slot_to_out(tail_reg.slot)
                                          : lfu_pkg::slot_to_out(tail_reg.best_slot);
            ev_valid_reg <= !tail_reg.done;
            ev_page_reg  <= tail_reg.done ? 16'd0 : lfu_pkg::page_to_out(tail_reg.best_tag);
            total_reg    <= fault_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.hit           = hit_reg;
    assign rsp.frame_slot    = slot_reg;
    assign rsp.evicted_valid = ev_valid_reg;
    assign rsp.evicted_page  = ev_page_reg;
    assign rsp.fault_total   = total_reg;

endmodule

@@ tb/lfu_page_replacement_tb.sv @@
// ----------------------------------------------------------------------------
// lfu_page_replacement_tb: self-checking bench for lfu page replacement
// Drives page references through the request channel, keeps its own
// frame table to predict hit, slot, evicted page and fault count for each
// reference, and checks every response word in order. The frame count is
// changed between phases, including zero, one, sixteen and out-of-range
// settings, and both channels idle at random.
// ----------------------------------------------------------------------------
module lfu_page_replacement_tb;

    localparam int SETTLE     = lfu_pkg::MAX_FRAMES + 6;
    localparam int IDLE_LIMIT = 4000;
    localparam int PHASES     = 10;
    localparam int PER_PHASE  = 195;

    typedef struct packed {
        logic        hit;
        logic [3:0]  slot;
        logic        ev_valid;
        logic [15:0] ev_page;
        logic [31:0] faults;
    } lfu_result_t;

    class lfu_scoreboard;
        logic              occupied[lfu_pkg::MAX_FRAMES];
        lfu_pkg::page_t    tag[lfu_pkg::MAX_FRAMES];
        lfu_pkg::count_t   uses[lfu_pkg::MAX_FRAMES];
        lfu_pkg::stamp_t   loaded_at[lfu_pkg::MAX_FRAMES];
        lfu_pkg::stamp_t   ref_count;
        logic [31:0]       faults;
        logic [4:0]        frames_cfg;
        lfu_result_t       awaited[$];
        int                mismatches;

        function new();
            for (int s = 0; s < lfu_pkg::MAX_FRAMES; s++)
            begin
                occupied[s]  = 1'b0;
                tag[s]       = '0;
                uses[s]      = '0;
                loaded_at[s] = '0;
            end
            ref_count  = '0;
            faults     = '0;
            frames_cfg = 5'd16;
            mismatches = 0;
        endfunction

        function void set_frames(logic [4:0] v);
            frames_cfg = v;
        endfunction

        function void load_frame(int s, lfu_pkg::page_t pg);
            occupied[s]  = 1'b1;
            tag[s]       = pg;
            uses[s]      = lfu_pkg::count_t'(1);
            loaded_at[s] = ref_count;
            if (faults != '1)
                faults++;
        endfunction

        // works out the response word for one accepted reference
        function void note_page(logic [15:0] page_in);
            lfu_pkg::page_t pg;
            int             n;
            int             victim;
            bit             placed;
            lfu_result_t    r;
            pg     = page_in[lfu_pkg::PAGE_BITS-1:0];
            n      = (frames_cfg == 0) ? 1 :
                     ((frames_cfg > lfu_pkg::MAX_FRAMES) ? lfu_pkg::MAX_FRAMES
                                                          : int'(frames_cfg));
            r      = '0;
            placed = 1'b0;
            for (int s = 0; s < n && !placed; s++)
            begin
                if (!occupied[s])
                begin
                    load_frame(s, pg);
                    r.slot = 4'(s);
                    placed = 1'b1;
                end
                else if (tag[s] == pg)
                begin
                    if (uses[s] != lfu_pkg::COUNT_MAX)
                        uses[s]++;
                    r.hit  = 1'b1;
                    r.slot = 4'(s);
                    placed = 1'b1;
                end
            end
            if (!placed)
            begin
                // lowest use count, then oldest load, then lowest slot
                victim = 0;
                for (int s = 1; s < n; s++)
                begin
                    if (uses[s] < uses[victim] ||
                        (uses[s] == uses[victim] && loaded_at[s] < loaded_at[victim]))
                        victim = s;
                end
                r.ev_valid = 1'b1;
                r.ev_page  = 16'(tag[victim]);
                load_frame(victim, pg);
                r.slot = 4'(victim);
            end
            if (ref_count != '1)
                ref_count++;
            r.faults = faults;
            awaited.push_back(r);
        endfunction

        function void check_result(lfu_result_t got);
            lfu_result_t want;
            bit          bad;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: hit=%0d slot=%0d ev=%0d %s=%h faults=%0d",
                             got.hit, got.slot, got.ev_valid, "ev_page",
                             got.ev_page, got.faults);
                return;
            end
            want = awaited.pop_front();
            bad  = (got.hit !== want.hit) || (got.slot !== want.slot) ||
                   (got.ev_valid !== want.ev_valid) || (got.ev_page !== want.ev_page) ||
                   (got.faults !== want.faults);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: exp hit=%0d slot=%0d ev=%0d ev_page=%h faults=%0d",
                             want.hit, want.slot, want.ev_valid, want.ev_page,
                             want.faults);
                    $display("          got hit=%0d slot=%0d ev=%0d ev_page=%h faults=%0d",
                             got.hit, got.slot, got.ev_valid, got.ev_page, got.faults);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    int   idle_cycles = 0;

    logic [4:0] phase_frames [PHASES] =
        '{5'd1, 5'd16, 5'd4, 5'd0, 5'd31, 5'd8, 5'd17, 5'd2, 5'd16, 5'd3};

    lfu_scoreboard sb;

    lfu_req_if req();
    lfu_rsp_if rsp();
    lfu_cfg_if cfg();

    lfu_page_replacement dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // response side: check accepted words, stall at random
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result('{rsp.hit, rsp.frame_slot, rsp.evicted_valid,
                              rsp.evicted_page, rsp.fault_total});
        rsp.ready <= rst_n && (steady || $urandom_range(0, 99) >= 17);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
                (cfg.valid && cfg.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_page(input logic [15:0] p);
        if (!steady)
            while ($urandom_range(0, 99) < 17)
            begin
                req.valid <= 1'b0;
                @(posedge clk);
            end
        req.valid       <= 1'b1;
        req.page_number <= p;
        do @(posedge clk); while (!req.ready);
        sb.note_page(p);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        do @(posedge clk); while (sb.awaited.size() != 0);
    endtask

    task automatic reconfigure(input logic [4:0] v);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg.valid         <= 1'b1;
        cfg.frames_in_use <= v;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        sb.set_frames(v);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [15:0] pool[$];
        logic [4:0]  fr;
        int          n_eff;
        int          span;
        bit          narrow;
        req.valid         = 1'b0;
        req.page_number   = '0;
        cfg.valid         = 1'b0;
        cfg.frames_in_use = '0;
        steady            = 1'b0;
        rst_n             = 1'b0;
        sb                = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill, hits, extremes of the page field
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'hFFFF);
        // two frames: equal counts go to the older load
        reconfigure(5'd2);
        send_page(16'h1234);
        send_page(16'hFFFF);
        send_page(16'h00AA);
        // empty frame taken before any eviction, then a stamp tie-break
        reconfigure(5'd3);
        send_page(16'h5555);
        send_page(16'hAAAA);
        // zero frames behaves as one
        reconfigure(5'd0);
        send_page(16'h0F0F);
        send_page(16'h0F0F);
        // oversized count: frames left out kept their pages
        reconfigure(5'd31);
        send_page(16'h5555);
        send_page(16'hFFFF);
        send_page(16'h8001);
        reconfigure(5'd17);
        send_page(16'h7FFE);
        reconfigure(5'd1);
        send_page(16'hFFFF);
        send_page(16'hFFFF);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            fr = (ph == 7) ? 5'($urandom_range(0, 31)) : phase_frames[ph];
            reconfigure(fr);
            steady = (ph == 5);
            n_eff  = (fr == 0) ? 1 :
                     ((fr > lfu_pkg::MAX_FRAMES) ? lfu_pkg::MAX_FRAMES : int'(fr));
            span   = $urandom_range(1, 2 * n_eff + 2);
            narrow = $urandom_range(0, 1);
            pool.delete();
            for (int k = 0; k < span; k++)
                pool.push_back(narrow ? 16'($urandom_range(0, 31))
                                      : 16'($urandom_range(0, 65535)));
            for (int i = 0; i < PER_PHASE; i++)
            begin
                // hold off until the pipe is empty now and then
                if ($urandom_range(0, 199) == 0)
                    drain();
                if ($urandom_range(0, 99) < 85)
                    send_page(pool[$urandom_range(0, pool.size() - 1)]);
                else
                    send_page(16'($urandom_range(0, 65535)));
            end
        end
        steady = 1'b0;

        drain();
        repeat (4 * (lfu_pkg::MAX_FRAMES + 2)) @(posedge clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
